>>> design/hfed_pkg.sv
// Shared constants and types of the Hilbert FIR envelope detector.
package hfed_pkg;

	localparam int NUM_SCANLINES = 256;
	localparam int NUM_TAPS      = 65;
	localparam int SAMPLE_BITS   = 16;

	localparam int LINE_LEN  = NUM_TAPS - 1;
	localparam int HALF_TAPS = NUM_TAPS / 2;
	localparam int FILL_W    = $clog2(HALF_TAPS + 1);

	localparam int SL_W      = 8;
	localparam int CIDX_W    = 7;
	localparam int COEF_W    = 18;
	localparam int COEF_FRAC = 17;

	localparam int PROD_W = SAMPLE_BITS + COEF_W;
	localparam int GRP    = 8;
	localparam int NGRP   = (NUM_TAPS + GRP - 1) / GRP;
	localparam int PART_W = PROD_W + $clog2(GRP);
	localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS);
	localparam int Q_W    = ACC_W - COEF_FRAC;

	localparam int MAG_BITS  = 18;
	localparam int ENV_MAX   = (1 << MAG_BITS) - 1;
	localparam int MAG_LIMIT = 1 << MAG_BITS;
	localparam int X_W       = 2 * MAG_BITS + 1;
	localparam int R_W       = X_W + 1;
	localparam int NIT       = (X_W + 1) / 2;
	localparam int NSQ       = (NIT + 1) / 2;
	localparam int NST       = 6 + NSQ;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_SAMPLE  = 2'd1,
		OP_PAD     = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef struct packed {
		logic [LINE_LEN-1:0][SAMPLE_BITS-1:0] smp;
		logic [FILL_W-1:0]                    fill;
	} row_t;

endpackage

>>> design/hilbert_fir_envelope_detector_top.sv
// Top level of the Hilbert FIR envelope detector.
//
//  channel  | handshake            | word
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_ready  | opcode, scanline, sample, coef_index,
//           |                      | coef_value
//  output   | out_valid / out_ready| envelope, result_scanline
//
// One word is taken every cycle while in_ready is high; the scanline row store
// (one read and one write port, a whole row per access) sets that rate, with
// back-to-back words to one scanline served by a bypass of the row just written.
// A result passes through the input register, products, two adder-tree stages,
// magnitudes, squares, then ten square-root stages of up to two digits each.
// Reset clears the row valid bits and the pipeline valids; no clearing pass.
// A stall at the output holds only full stages; bubbles keep closing up.
module hilbert_fir_envelope_detector_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      opcode,
	input  logic [hfed_pkg::SL_W-1:0]       scanline,
	input  logic signed [hfed_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [hfed_pkg::CIDX_W-1:0]     coef_index,
	input  logic signed [hfed_pkg::COEF_W-1:0] coef_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hfed_pkg::MAG_BITS-1:0]   envelope,
	output logic [hfed_pkg::SL_W-1:0]       result_scanline
);

	localparam int NT  = hfed_pkg::NUM_TAPS;
	localparam int SW  = hfed_pkg::SAMPLE_BITS;
	localparam int LL  = hfed_pkg::LINE_LEN;
	localparam int HT  = hfed_pkg::HALF_TAPS;
	localparam int NST = hfed_pkg::NST;
	localparam int NSQ = hfed_pkg::NSQ;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;
	logic           in_acc;

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[0];
	assign in_acc   = in_valid && en[0];

	// stage 1: word plus the row read for its scanline
	hfed_pkg::op_t                   op_s1;
	logic [hfed_pkg::SL_W-1:0]       sl_s1;
	logic signed [SW-1:0]            smp_s1;
	logic [hfed_pkg::CIDX_W-1:0]     cidx_s1;
	logic signed [hfed_pkg::COEF_W-1:0] cval_s1;
	hfed_pkg::row_t                  rowraw_s1;
	logic                            rvld_s1;
	logic                            fwd_s1;

	hfed_pkg::row_t                  mem [hfed_pkg::NUM_SCANLINES];
	logic [hfed_pkg::NUM_SCANLINES-1:0] rvld_q;
	hfed_pkg::row_t                  lrow_q;
	logic signed [hfed_pkg::COEF_W-1:0] coef_q [NT];

	hfed_pkg::row_t       row_cur;
	hfed_pkg::row_t       row_new;
	logic signed [SW-1:0] win [NT];
	logic signed [SW-1:0] newest;
	logic                 in_range;
	logic                 is_push;
	logic                 wr_en;
	logic                 cf_en;
	logic                 emit;

	always_comb begin
		in_range = {1'b0, sl_s1} < (hfed_pkg::SL_W + 1)'(hfed_pkg::NUM_SCANLINES);
		is_push  = (op_s1 == hfed_pkg::OP_SAMPLE) || (op_s1 == hfed_pkg::OP_PAD);
		newest   = (op_s1 == hfed_pkg::OP_SAMPLE) ? smp_s1 : '0;
		if (fwd_s1) begin
			row_cur = lrow_q;
		end else if (rvld_s1) begin
			row_cur = rowraw_s1;
		end else begin
			row_cur = '0;
		end
		for (int j = 0; j < LL; j++) begin
			win[j] = $signed(row_cur.smp[j]);
		end
		win[NT-1] = newest;

		row_new = '0;
		if (op_s1 != hfed_pkg::OP_RESTART) begin
			for (int j = 0; j < LL - 1; j++) begin
				row_new.smp[j] = row_cur.smp[j+1];
			end
			row_new.smp[LL-1] = newest;
			row_new.fill = (32'(row_cur.fill) < HT) ? row_cur.fill + 1'b1 : row_cur.fill;
		end

		wr_en = vld_q[0] && en[1] && in_range &&
			(is_push || (op_s1 == hfed_pkg::OP_RESTART));
		cf_en = vld_q[0] && en[1] && (op_s1 == hfed_pkg::OP_LOAD) &&
			({1'b0, cidx_s1} < (hfed_pkg::CIDX_W + 1)'(NT));
		emit  = in_range && is_push && (32'(row_cur.fill) >= HT);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rowraw_s1 <= mem[scanline];
		end
		if (wr_en) begin
			mem[sl_s1] <= row_new;
			lrow_q     <= row_new;
		end
		if (cf_en) begin
			coef_q[cidx_s1[$clog2(NT)-1:0]] <= cval_s1;
		end
		if (in_acc) begin
			op_s1   <= hfed_pkg::op_t'(opcode);
			sl_s1   <= scanline;
			smp_s1  <= sample;
			cidx_s1 <= coef_index;
			cval_s1 <= coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q  <= '0;
			rvld_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			if (in_acc) begin
				rvld_s1 <= rvld_q[scanline];
				// the row written at this edge is missing from the read: bypass it
				fwd_s1  <= wr_en && (sl_s1 == scanline);
			end
			if (wr_en) begin
				rvld_q[sl_s1] <= 1'b1;
			end
		end
	end

	// stage 2: products
	logic signed [hfed_pkg::PROD_W-1:0] p_s2 [NT];
	logic signed [SW-1:0]               ctr_s2;
	logic [hfed_pkg::SL_W-1:0]          sl_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < NT; k++) begin
				p_s2[k] <= hfed_pkg::PROD_W'(win[k]) * hfed_pkg::PROD_W'(coef_q[k]);
			end
			ctr_s2 <= win[HT];
			sl_s2  <= sl_s1;
		end
	end

	// stage 3: partial sums of up to eight taps
	logic signed [hfed_pkg::PART_W-1:0] part_s3 [hfed_pkg::NGRP];
	logic signed [hfed_pkg::PART_W-1:0] part_d  [hfed_pkg::NGRP];
	logic signed [SW-1:0]               ctr_s3;
	logic [hfed_pkg::SL_W-1:0]          sl_s3;

	always_comb begin
		for (int g = 0; g < hfed_pkg::NGRP; g++) begin
			part_d[g] = '0;
			for (int i = 0; i < hfed_pkg::GRP; i++) begin
				if (g * hfed_pkg::GRP + i < NT) begin
					part_d[g] = part_d[g] +
						hfed_pkg::PART_W'(p_s2[g * hfed_pkg::GRP + i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			part_s3 <= part_d;
			ctr_s3  <= ctr_s2;
			sl_s3   <= sl_s2;
		end
	end

	// stage 4: full dot product
	logic signed [hfed_pkg::ACC_W-1:0] acc_s4;
	logic signed [hfed_pkg::ACC_W-1:0] acc_d;
	logic signed [SW-1:0]              ctr_s4;
	logic [hfed_pkg::SL_W-1:0]         sl_s4;

	always_comb begin
		acc_d = '0;
		for (int g = 0; g < hfed_pkg::NGRP; g++) begin
			acc_d = acc_d + hfed_pkg::ACC_W'(part_s3[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			acc_s4 <= acc_d;
			ctr_s4 <= ctr_s3;
			sl_s4  <= sl_s3;
		end
	end

	// stage 5: magnitudes and saturation
	logic signed [hfed_pkg::Q_W-1:0] q_d;
	logic [hfed_pkg::Q_W-1:0]        mq_d;
	logic [SW:0]                     mi_d;
	logic [hfed_pkg::MAG_BITS-1:0]   mq_s5;
	logic [hfed_pkg::MAG_BITS-1:0]   mi_s5;
	logic                            sat_s5;
	logic [hfed_pkg::SL_W-1:0]       sl_s5;

	always_comb begin
		q_d  = hfed_pkg::Q_W'(acc_s4 >>> hfed_pkg::COEF_FRAC);
		mq_d = q_d[hfed_pkg::Q_W-1] ? hfed_pkg::Q_W'(-q_d) : hfed_pkg::Q_W'(q_d);
		mi_d = ctr_s4[SW-1] ? (SW + 1)'(-(SW + 1)'(ctr_s4)) : (SW + 1)'(ctr_s4);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			mq_s5  <= hfed_pkg::MAG_BITS'(mq_d);
			mi_s5  <= hfed_pkg::MAG_BITS'(mi_d);
			sat_s5 <= (64'(mq_d) >= 64'(hfed_pkg::MAG_LIMIT)) ||
				(64'(mi_d) >= 64'(hfed_pkg::MAG_LIMIT));
			sl_s5  <= sl_s4;
		end
	end

	// stage 6: sum of squares
	logic [2*hfed_pkg::MAG_BITS-1:0] si_d;
	logic [2*hfed_pkg::MAG_BITS-1:0] sq_d;
	logic [hfed_pkg::X_W-1:0]        x_s6;
	logic                            sat_s6;
	logic [hfed_pkg::SL_W-1:0]       sl_s6;

	always_comb begin
		si_d = mi_s5 * mi_s5;
		sq_d = mq_s5 * mq_s5;
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			x_s6   <= hfed_pkg::X_W'(si_d) + hfed_pkg::X_W'(sq_d);
			sat_s6 <= sat_s5;
			sl_s6  <= sl_s5;
		end
	end

	// square root, up to two digits per stage
	logic [hfed_pkg::R_W-1:0]  sqx_q   [NSQ];
	logic [hfed_pkg::R_W-1:0]  sqr_q   [NSQ];
	logic                      sqsat_q [NSQ];
	logic [hfed_pkg::SL_W-1:0] sqsl_q  [NSQ];
	logic [hfed_pkg::R_W-1:0]  sqx_d   [NSQ];
	logic [hfed_pkg::R_W-1:0]  sqr_d   [NSQ];

	always_comb begin
		logic [hfed_pkg::R_W-1:0] x;
		logic [hfed_pkg::R_W-1:0] r;
		logic [hfed_pkg::R_W-1:0] b;
		for (int j = 0; j < NSQ; j++) begin
			if (j == 0) begin
				x = hfed_pkg::R_W'(x_s6);
				r = '0;
			end else begin
				x = sqx_q[j-1];
				r = sqr_q[j-1];
			end
			for (int i = 0; i < 2; i++) begin
				if (2 * j + i < hfed_pkg::NIT) begin
					b = hfed_pkg::R_W'(1) << (2 * (hfed_pkg::NIT - 1 - (2 * j + i)));
					if (x >= r + b) begin
						x = x - (r + b);
						r = (r >> 1) + b;
					end else begin
						r = r >> 1;
					end
				end
			end
			sqx_d[j] = x;
			sqr_d[j] = r;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NSQ; j++) begin
			if (en[6+j]) begin
				sqx_q[j] <= sqx_d[j];
				sqr_q[j] <= sqr_d[j];
				if (j == 0) begin
					sqsat_q[j] <= sat_s6;
					sqsl_q[j]  <= sl_s6;
				end else begin
					sqsat_q[j] <= sqsat_q[j-1];
					sqsl_q[j]  <= sqsl_q[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			// drop words that give no result
			if (en[1]) begin
				vld_q[1] <= vld_q[0] && emit;
			end
			for (int k = 2; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign out_valid       = vld_q[NST-1];
	assign result_scanline = sqsl_q[NSQ-1];
	assign envelope = (sqsat_q[NSQ-1] ||
		(sqr_q[NSQ-1] > hfed_pkg::R_W'(hfed_pkg::ENV_MAX))) ?
		hfed_pkg::MAG_BITS'(hfed_pkg::ENV_MAX) : sqr_q[NSQ-1][hfed_pkg::MAG_BITS-1:0];

endmodule

>>> tb/sv/tb.sv
// Testbench for the Hilbert FIR envelope detector: queue-fed driver, monitor, predictor.
`timescale 1ns / 1ps

module tb;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_ready;
	logic [1:0]                             opcode = hfed_pkg::OP_PAD;
	logic [hfed_pkg::SL_W-1:0]              scanline = '0;
	logic signed [hfed_pkg::SAMPLE_BITS-1:0] sample = '0;
	logic [hfed_pkg::CIDX_W-1:0]            coef_index = '0;
	logic signed [hfed_pkg::COEF_W-1:0]     coef_value = '0;
	logic                                   out_valid;
	logic                                   out_ready = 1'b0;
	logic [hfed_pkg::MAG_BITS-1:0]          envelope;
	logic [hfed_pkg::SL_W-1:0]              result_scanline;

	hilbert_fir_envelope_detector_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .scanline(scanline), .sample(sample),
		.coef_index(coef_index), .coef_value(coef_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.envelope(envelope), .result_scanline(result_scanline)
	);

	always #6 clk = ~clk;

	typedef struct packed {
		logic [1:0]                  op;
		logic [hfed_pkg::SL_W-1:0]   sl;
		logic [15:0]                 smp;
		logic [hfed_pkg::CIDX_W-1:0] cidx;
		logic [hfed_pkg::COEF_W-1:0] cval;
	} word_t;

	typedef struct packed {
		logic [hfed_pkg::MAG_BITS-1:0] env;
		logic [hfed_pkg::SL_W-1:0]     sl;
	} env_t;

	word_t pending[$];
	env_t  env_q[$];

	// predictor state
	int  lines[hfed_pkg::NUM_SCANLINES][hfed_pkg::LINE_LEN];
	int  coefs[hfed_pkg::NUM_TAPS];
	int  fills[hfed_pkg::NUM_SCANLINES];
	int  fails = 0;
	int  sent = 0;
	int  got = 0;
	int  saturated = 0;
	longint cycles = 0;

	function automatic longint root_floor(longint x);
		longint r;
		r = longint'($floor($sqrt(real'(x))));
		while (r * r > x) r--;
		while ((r + 1) * (r + 1) <= x) r++;
		return r;
	endfunction

	function automatic void predict_envelope(word_t w);
		longint acc, q, mi, mq, env;
		int newest, center;
		if (w.op == hfed_pkg::OP_LOAD) begin
			if (w.cidx < hfed_pkg::NUM_TAPS) coefs[w.cidx] = $signed(w.cval);
			return;
		end
		if (w.op == hfed_pkg::OP_RESTART) begin
			for (int j = 0; j < hfed_pkg::LINE_LEN; j++) lines[w.sl][j] = 0;
			fills[w.sl] = 0;
			return;
		end
		newest = (w.op == hfed_pkg::OP_SAMPLE) ? $signed(w.smp) : 0;
		acc = 0;
		for (int j = 0; j < hfed_pkg::LINE_LEN; j++)
			acc += longint'(lines[w.sl][j]) * coefs[j];
		acc += longint'(newest) * coefs[hfed_pkg::NUM_TAPS-1];
		center = lines[w.sl][hfed_pkg::HALF_TAPS];
		for (int j = 0; j < hfed_pkg::LINE_LEN - 1; j++) lines[w.sl][j] = lines[w.sl][j+1];
		lines[w.sl][hfed_pkg::LINE_LEN-1] = newest;
		if (fills[w.sl] < hfed_pkg::HALF_TAPS) begin
			fills[w.sl]++;
			return;
		end
		q = acc >>> hfed_pkg::COEF_FRAC;
		mi = center < 0 ? -center : center;
		mq = q < 0 ? -q : q;
		if (mi >= hfed_pkg::MAG_LIMIT || mq >= hfed_pkg::MAG_LIMIT) begin
			env = hfed_pkg::ENV_MAX;
			saturated++;
		end else begin
			env = root_floor(mi * mi + mq * mq);
			if (env > hfed_pkg::ENV_MAX) env = hfed_pkg::ENV_MAX;
		end
		env_q.push_back({env[hfed_pkg::MAG_BITS-1:0], w.sl});
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_envelope({opcode, scanline, sample, coef_index, coef_value});
				sent <= sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					word_t w;
					w = pending.pop_front();
					in_valid <= 1'b1;
					opcode <= w.op;
					scanline <= w.sl;
					sample <= w.smp;
					coef_index <= w.cidx;
					coef_value <= w.cval;
					in_gap <= gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				env_t e;
				got <= got + 1;
				if (env_q.size() == 0) begin
					$error("unexpected result: envelope %0d scanline %0d",
						envelope, result_scanline);
					fails++;
				end else begin
					e = env_q.pop_front();
					if (envelope !== e.env) begin
						$error("envelope: expected %0d, got %0d", e.env, envelope);
						fails++;
					end
					if (result_scanline !== e.sl) begin
						$error("result_scanline: expected %0d, got %0d", e.sl,
							result_scanline);
						fails++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_gap <= (cycles % 3000 < 1500) ? 0 : gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic word_t mk(logic [1:0] op, int sl, int smp, int ci, int cv);
		word_t w;
		w.op = op;
		w.sl = hfed_pkg::SL_W'(sl);
		w.smp = 16'(smp);
		w.cidx = hfed_pkg::CIDX_W'(ci);
		w.cval = hfed_pkg::COEF_W'(cv);
		return w;
	endfunction

	// Hilbert-like taps: odd offsets from center, 1/k shape, or fully random taps
	task automatic load_taps(int scale, bit rnd);
		int v, k;
		for (int t = 0; t < hfed_pkg::NUM_TAPS; t++) begin
			k = t - hfed_pkg::HALF_TAPS;
			if (rnd) v = $signed(18'($urandom));
			else if (k % 2 == 0) v = 0;
			else v = scale / k;
			pending.push_back(mk(hfed_pkg::OP_LOAD, $urandom_range(0, 255), $urandom, t, v));
		end
	endtask

	task automatic push_line(int sl, int n, int mode);
		int s;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: s = $urandom;
				1: s = (i % 2) ? 32767 : -32768;
				default: s = $urandom_range(0, 2000) - 1000;
			endcase
			if ($urandom_range(0, 15) == 0)
				pending.push_back(mk(hfed_pkg::OP_PAD, sl, $urandom, $urandom, $urandom));
			else
				pending.push_back(mk(hfed_pkg::OP_SAMPLE, sl, s, $urandom, $urandom));
		end
	endtask

	task automatic drain();
		wait (pending.size() == 0);
		wait (!in_valid && env_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		for (int s = 0; s < hfed_pkg::NUM_SCANLINES; s++) begin
			fills[s] = 0;
			for (int j = 0; j < hfed_pkg::LINE_LEN; j++) lines[s][j] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: full taps first, then out-of-range index, extremes, restart
		load_taps(131071, 0);
		pending.push_back(mk(hfed_pkg::OP_LOAD, 0, 0, 65, 18'h1ffff));
		pending.push_back(mk(hfed_pkg::OP_LOAD, 0, 0, 127, 18'h20000));
		pending.push_back(mk(hfed_pkg::OP_SAMPLE, 255, 16'h8000, 0, 0));
		pending.push_back(mk(hfed_pkg::OP_SAMPLE, 255, 16'h7fff, 0, 0));
		pending.push_back(mk(hfed_pkg::OP_PAD, 255, 16'hffff, 0, 0));
		pending.push_back(mk(hfed_pkg::OP_RESTART, 255, 0, 0, 0));
		push_line(0, 40, 1);
		push_line(3, 34, 0);
		pending.push_back(mk(hfed_pkg::OP_RESTART, 3, 0, 0, 0));
		push_line(3, 33, 2);
		drain();

		// extreme taps to force saturation
		for (int t = 0; t < hfed_pkg::NUM_TAPS; t++)
			pending.push_back(mk(hfed_pkg::OP_LOAD, 0, 0, t,
				(t % 2) ? 18'h20000 : 18'h1ffff));
		push_line(7, 50, 1);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 2) load_taps(0, 1);
			else load_taps(phase == 0 ? 60000 : 131071, 0);
			// round-robin over a few lines, with occasional restarts and stray loads
			for (int n = 0; n < 100; n++) begin
				int sl;
				sl = (n % 5 == 4) ? $urandom_range(0, 255) : (n % 4) * 60 + phase;
				if ($urandom_range(0, 9) == 0)
					pending.push_back(mk(hfed_pkg::OP_RESTART, sl, $urandom, $urandom,
						$urandom));
				else if ($urandom_range(0, 19) == 0)
					pending.push_back(mk(hfed_pkg::OP_LOAD, sl, $urandom,
						65 + $urandom_range(0, 62), $urandom));
				else
					push_line(sl, 4, $urandom_range(0, 2));
			end
			drain();
		end

		$display("Covered %0d words in, %0d envelope results, %0d saturated.",
			sent, got, saturated);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> hilbert_fir_envelope_detector_top.f
design/hfed_pkg.sv
design/hilbert_fir_envelope_detector_top.sv
tb/sv/tb.sv
